// ----- hw/rtl/lsb_pkg.sv -----
// Shared types and constants of the lottery scheduler with boost.
package lsb_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int TICKET_W = 16;
    localparam int TOTAL_W  = 23;
    localparam int DRAW_W   = 31;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 23'h7fffff;

    localparam logic [DRAW_W-1:0] LCG_MUL = 31'(32'd1103515245);
    localparam logic [DRAW_W-1:0] LCG_ADD = 31'd12345;

    typedef enum logic [FUNC_W-1:0] {
        FN_STATUS  = 2'd0,
        FN_TICKETS = 2'd1,
        FN_ROUND   = 2'd2,
        FN_NONE    = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMBRYO   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SLEEPING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUNNABLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SUM,
        S_GEN_MUL,
        S_GEN_ADD,
        S_MOD,
        S_PICK,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/lsb_req_if.sv -----
// Request channel: one table update or scheduling round per request.
interface lsb_req_if
    import lsb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SLOT_W-1:0]   slot_index;
    logic [STATUS_W-1:0] new_status;
    logic [TICKET_W-1:0] ticket_count;

    modport source (output valid, func, slot_index, new_status, ticket_count, input ready);
    modport sink   (input valid, func, slot_index, new_status, ticket_count, output ready);
endinterface

// ----- hw/rtl/lsb_rsp_if.sv -----
// Response channel: one result per request.
interface lsb_rsp_if
    import lsb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               granted;
    logic [SLOT_W-1:0]  winner_slot;
    logic [TOTAL_W-1:0] weight_total;
    logic [DRAW_W-1:0]  draw_value;

    modport source (output valid, granted, winner_slot, weight_total, draw_value, input ready);
    modport sink   (input valid, granted, winner_slot, weight_total, draw_value, output ready);
endinterface

// ----- hw/rtl/lottery_scheduler_with_boost_unit.sv -----
// Lottery scheduler with sleep boost: slot table, generator and round sequencer.
// A request updates one slot's status or tickets, or runs one
// scheduling round. A round makes one pass over the slot table memory
// to raise sleeping boosts and sum runnable weights, a generator step
// (multiply, then add), a remainder of the draw by the weight total in
// the bit-serial remainder unit, and a second pass that stops at
// the winning slot. The slot table memory, read one slot per cycle, sets
// the pass length. An empty round skips the draw and the second pass. The
// table starts all zero through per-slot valid bits, so no clearing pass is
// needed after reset. Every request yields exactly one response; the response
// register holds it until taken. Writing random_seed (address 0) loads the
// generator; do so only while no request is in flight.
module lottery_scheduler_with_boost_unit
    import lsb_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int BOOST_LIMIT = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    lsb_req_if.sink     req,
    lsb_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BW    = $clog2(BOOST_LIMIT + 1);
    localparam int ENT_W = STATUS_W + TICKET_W + BW;
    localparam int SUM_W = TICKET_W + 1 + IDX_W;

    // slot table: {status, tickets, boost}
    logic [ENT_W-1:0] mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    func_t               func_reg, func_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [TICKET_W-1:0] tk_reg, tk_next;
    logic                inr_reg, inr_next;
    logic [SUM_W-1:0]    total_reg, total_next;
    logic [SUM_W-1:0]    run_reg, run_next;
    logic [SUM_W-1:0]    pick_reg, pick_next;
    logic [DRAW_W-1:0]   prod_reg, prod_next;
    logic [31:0]         gen_reg, gen_next;
    logic                gnt_reg, gnt_next;
    logic [IDX_W-1:0]    win_reg, win_next;
    logic [DRAW_W-1:0]   draw_reg, draw_next;

    logic                out_vld_reg, out_vld_next;
    logic                out_gnt_reg, out_gnt_next;
    logic [SLOT_W-1:0]   out_win_reg, out_win_next;
    logic [TOTAL_W-1:0]  out_tot_reg, out_tot_next;
    logic [DRAW_W-1:0]   out_drw_reg, out_drw_next;

    logic                in_acc;
    logic                last_slot;
    logic [ENT_W-1:0]    ent;
    logic [STATUS_W-1:0] ent_st;
    logic [TICKET_W-1:0] ent_tk;
    logic [BW-1:0]       ent_bo;
    logic [SUM_W-1:0]    cur_w;
    logic [SUM_W-1:0]    tot_sum;
    logic [SUM_W-1:0]    run_sum;
    logic                hit;
    logic                empty_round;
    logic [DRAW_W-1:0]   draw_c;
    logic                mod_start;
    logic                mod_done;
    logic [SUM_W-1:0]    mod_rem;
    logic [31:0]         tot_ext;
    logic [31:0]         win_ext;
    logic                load_out;
    logic                cfg_we;

    // decode the entry read last cycle; a never-written slot reads as zero
    assign ent       = rd_vld_reg ? rd_data_reg : '0;
    assign ent_st    = ent[ENT_W-1 -: STATUS_W];
    assign ent_tk    = ent[BW +: TICKET_W];
    assign ent_bo    = ent[BW-1:0];
    assign cur_w     = (ent_bo != '0) ? SUM_W'({ent_tk, 1'b0}) : SUM_W'(ent_tk);
    assign tot_sum   = (ent_st == ST_RUNNABLE) ? total_reg + cur_w : total_reg;
    assign run_sum   = run_reg + cur_w;
    assign hit       = (ent_st == ST_RUNNABLE) && (run_sum > pick_reg);
    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign empty_round = (tot_sum == '0);
    assign draw_c    = prod_reg + LCG_ADD;
    assign in_acc    = req.valid && req.ready;
    assign load_out  = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);

    // APB: random_seed at address 0
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : gen_reg;
    assign cfg_we = psel && penable && pwrite && !paddr[2];

    lsb_mod #(
        .VW(SUM_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (draw_c),
        .divisor  (total_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (func_t'(req.func) == FN_ROUND) ? S_SUM : S_UPD;
                end
            end
            S_UPD:     state_next = S_DONE;
            S_SUM:
            begin
                if (last_slot)
                begin
                    state_next = empty_round ? S_DONE : S_GEN_MUL;
                end
            end
            S_GEN_MUL: state_next = S_GEN_ADD;
            S_GEN_ADD: state_next = S_MOD;
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (hit || last_slot)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next   = idx_reg;
        func_next  = func_reg;
        st_next    = st_reg;
        tk_next    = tk_reg;
        inr_next   = inr_reg;
        total_next = total_reg;
        run_next   = run_reg;
        pick_next  = pick_reg;
        prod_next  = prod_reg;
        gen_next   = gen_reg;
        gnt_next   = gnt_reg;
        win_next   = win_reg;
        draw_next  = draw_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = ent;
        mem_raddr  = idx_reg + 1'b1;
        mod_start  = 1'b0;
        tot_ext    = 32'(total_reg);
        win_ext    = 32'(win_reg);

        out_vld_next = out_vld_reg;
        out_gnt_next = out_gnt_reg;
        out_win_next = out_win_reg;
        out_tot_next = out_tot_reg;
        out_drw_next = out_drw_reg;
        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cfg_we)
        begin
            gen_next = pwdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (in_acc)
                begin
                    func_next  = func_t'(req.func);
                    st_next    = req.new_status;
                    tk_next    = req.ticket_count;
                    inr_next   = (32'(req.slot_index) < 32'(SLOT_COUNT));
                    total_next = '0;
                    gnt_next   = 1'b0;
                    win_next   = '0;
                    draw_next  = '0;
                    if (func_t'(req.func) == FN_ROUND)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next  = IDX_W'(req.slot_index);
                        mem_raddr = IDX_W'(req.slot_index);
                    end
                end
            end
            S_UPD:
            begin
                if (inr_reg && func_reg == FN_STATUS)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {st_reg, ent_tk, (st_reg == ST_EMBRYO) ? BW'(0) : ent_bo};
                end
                else if (inr_reg && func_reg == FN_TICKETS)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {ent_st, tk_reg, ent_bo};
                end
            end
            S_SUM:
            begin
                // raise sleeping boosts, accumulate runnable weights
                total_next = tot_sum;
                idx_next   = idx_reg + 1'b1;
                if (ent_st == ST_SLEEPING && ent_bo < BW'(BOOST_LIMIT))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {ent_st, ent_tk, ent_bo + 1'b1};
                end
            end
            S_GEN_MUL:
            begin
                prod_next = DRAW_W'(gen_reg[DRAW_W-1:0] * LCG_MUL);
            end
            S_GEN_ADD:
            begin
                gen_next  = {1'b0, draw_c};
                draw_next = draw_c;
                mod_start = 1'b1;
            end
            S_MOD:
            begin
                mem_raddr = '0;
                idx_next  = '0;
                run_next  = '0;
                if (mod_done)
                begin
                    pick_next = mod_rem;
                end
            end
            S_PICK:
            begin
                idx_next = idx_reg + 1'b1;
                if (ent_st == ST_RUNNABLE)
                begin
                    run_next = run_sum;
                end
                if (hit)
                begin
                    // mark the winner running and spend one boost
                    mem_we    = 1'b1;
                    mem_wdata = {ST_RUNNING, ent_tk, (ent_bo != '0) ? ent_bo - 1'b1 : ent_bo};
                    gnt_next  = 1'b1;
                    win_next  = idx_reg;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_vld_next = 1'b1;
                    out_gnt_next = gnt_reg;
                    out_win_next = win_ext[SLOT_W-1:0];
                    out_tot_next = (tot_ext > 32'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];
                    out_drw_next = draw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.granted      = out_gnt_reg;
    assign rsp.winner_slot  = out_win_reg;
    assign rsp.weight_total = out_tot_reg;
    assign rsp.draw_value   = out_drw_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            gen_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= vld_reg[mem_raddr];
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            gen_reg     <= gen_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        func_reg    <= func_next;
        st_reg      <= st_next;
        tk_reg      <= tk_next;
        inr_reg     <= inr_next;
        total_reg   <= total_next;
        run_reg     <= run_next;
        pick_reg    <= pick_next;
        prod_reg    <= prod_next;
        gnt_reg     <= gnt_next;
        win_reg     <= win_next;
        draw_reg    <= draw_next;
        out_gnt_reg <= out_gnt_next;
        out_win_reg <= out_win_next;
        out_tot_reg <= out_tot_next;
        out_drw_reg <= out_drw_next;
    end
endmodule

// ----- hw/rtl/lsb_mod.sv -----
// Restoring remainder unit: one dividend bit per cycle.
module lsb_mod
    import lsb_pkg::*;
#(
    parameter int VW = 23
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DRAW_W-1:0] dividend,
    input  logic [VW-1:0]     divisor,
    output logic              done,
    output logic [VW-1:0]     rem
);
    localparam int CW = $clog2(DRAW_W + 1);

    logic              busy_reg, busy_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DRAW_W-1:0] dvd_reg, dvd_next;
    logic [VW-1:0]     dvs_reg, dvs_next;
    logic [VW:0]       rem_reg, rem_next;
    logic [VW:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[VW-1:0], dvd_reg[DRAW_W-1]};
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // subtract when the shifted remainder reaches the divisor
            rem_next = (trial >= {1'b0, dvs_reg}) ? trial - {1'b0, dvs_reg} : trial;
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DRAW_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (cnt_reg == CW'(DRAW_W))
        begin
            done     = 1'b1;
            cnt_next = '0;
        end
    end

    assign rem = rem_reg[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end
endmodule

// ----- dv/tb_lottery_scheduler_with_boost_unit.sv -----
// Testbench of the lottery scheduler with boost: directed table, random requests, self-check.
`timescale 1ns / 100ps

module tb_lottery_scheduler_with_boost_unit;
    import lsb_pkg::*;

    localparam int  N_SLOTS      = 64;
    localparam int  MAX_BOOST    = 15;
    localparam int  HALF_PERIOD  = 6;
    localparam int  STALL_LIMIT  = 20000;
    // Leave margin after a round before a seed write and at the end.
    localparam int  SETTLE_CYC   = 250;
    localparam int  ITEMS_PHASE  = 135;
    localparam logic [STATUS_W-1:0] ST_ZOMBIE = 3'd5;
    localparam logic [2:0] RG_SEED = 3'd0;
    localparam logic [31:0] GEN_MUL = 32'd1103515245;
    localparam logic [31:0] GEN_ADD = 32'd12345;

    typedef struct packed {
        func_t               func;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [TICKET_W-1:0] tickets;
    } sched_req_t;

    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  winner;
        logic [TOTAL_W-1:0] total;
        logic [DRAW_W-1:0]  draw;
    } sched_rsp_t;

    typedef struct {
        sched_req_t req;
        bit         typed;
        sched_rsp_t want;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lsb_req_if req_ch ();
    lsb_rsp_if rsp_ch ();

    lottery_scheduler_with_boost_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the slot table and the generator.
    logic [STATUS_W-1:0] shadow_status [N_SLOTS];
    logic [TICKET_W-1:0] shadow_tickets [N_SLOTS];
    int unsigned         shadow_boost [N_SLOTS];
    logic [31:0]         shadow_gen;

    sched_rsp_t   pending_rsp [$];
    table_row_t   directed [$];
    int unsigned  fail_count;
    int unsigned  idle_cycles;
    bit           no_idle;

    always #HALF_PERIOD clk = ~clk;

    // Weight of one slot: tickets, doubled while boosted.
    function automatic int unsigned slot_weight(int unsigned s);
        return (shadow_boost[s] != 0) ? 2 * shadow_tickets[s] : shadow_tickets[s];
    endfunction

    // Apply one request to the shadow table and return the response it should cause.
    function automatic sched_rsp_t schedule_step(sched_req_t r);
        sched_rsp_t      res;
        int unsigned     sum;
        int unsigned     pick;
        int unsigned     run;
        int unsigned     win;
        longint unsigned prod;
        res = '0;
        case (r.func)
            FN_STATUS:
            begin
                shadow_status[r.slot] = r.status;
                if (r.status == ST_EMBRYO)
                    shadow_boost[r.slot] = 0;
            end
            FN_TICKETS:
                shadow_tickets[r.slot] = r.tickets;
            FN_ROUND:
            begin
                sum = 0;
                for (int s = 0; s < N_SLOTS; s++)
                begin
                    if (shadow_status[s] == ST_SLEEPING)
                    begin
                        if (shadow_boost[s] < MAX_BOOST)
                            shadow_boost[s]++;
                    end
                    else if (shadow_status[s] == ST_RUNNABLE)
                        sum += slot_weight(s);
                end
                // Empty round: no draw, nothing but the sleeping boosts moves.
                if (sum != 0)
                begin
                    prod = longint'(shadow_gen) * longint'(GEN_MUL) + longint'(GEN_ADD);
                    shadow_gen = prod[31:0] & 32'h7fffffff;
                    pick = shadow_gen % sum;
                    run = 0;
                    win = N_SLOTS;
                    for (int s = 0; s < N_SLOTS; s++)
                    begin
                        if (shadow_status[s] == ST_RUNNABLE)
                        begin
                            run += slot_weight(s);
                            // Strictly greater: zero-ticket slots never win.
                            if (run > pick)
                            begin
                                win = s;
                                break;
                            end
                        end
                    end
                    if (win < N_SLOTS)
                    begin
                        if (shadow_boost[win] != 0)
                            shadow_boost[win]--;
                        shadow_status[win] = ST_RUNNING;
                        res.granted = 1'b1;
                        res.winner = win[SLOT_W-1:0];
                    end
                    res.total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    res.draw = shadow_gen[DRAW_W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Check each accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response", 32'd0, 32'd0);
            else
            begin
                sched_rsp_t want;
                want = pending_rsp.pop_front();
                if (rsp_ch.granted !== want.granted)
                    report_mismatch("granted", 32'(rsp_ch.granted), 32'(want.granted));
                if (rsp_ch.winner_slot !== want.winner)
                    report_mismatch("winner_slot", 32'(rsp_ch.winner_slot), 32'(want.winner));
                if (rsp_ch.weight_total !== want.total)
                    report_mismatch("weight_total", 32'(rsp_ch.weight_total), 32'(want.total));
                if (rsp_ch.draw_value !== want.draw)
                    report_mismatch("draw_value", 32'(rsp_ch.draw_value), 32'(want.draw));
            end
        end
    end

    // Stall the response side at random, except in the no-idle stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 18);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Two-phase register write; the register takes the value at the access edge.
    task automatic write_seed(logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = RG_SEED; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        shadow_gen = value;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Hold off until every response is in, then let the block settle.
    task automatic drain();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Send one request; record its expectation at the accepting edge.
    task automatic send_request(sched_req_t r, bit typed, sched_rsp_t want);
        sched_rsp_t pred;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 18)
            begin
                @(negedge clk);
                req_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.func = r.func;
        req_ch.slot_index = r.slot;
        req_ch.new_status = r.status;
        req_ch.ticket_count = r.tickets;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pred = schedule_step(r);
        pending_rsp.push_back(typed ? want : pred);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic add_row(func_t f, int s, logic [STATUS_W-1:0] st, int tk,
                           bit typed = 1'b0, sched_rsp_t want = '0);
        table_row_t row;
        row.req = '{func: f, slot: s[SLOT_W-1:0], status: st, tickets: tk[TICKET_W-1:0]};
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    // Table updates that feed runnable and sleeping slots, plus rounds and noise.
    function automatic sched_req_t random_request();
        sched_req_t r;
        int unsigned kind;
        kind = $urandom_range(99);
        r.slot = SLOT_W'($urandom_range(N_SLOTS - 1));
        r.status = STATUS_W'($urandom_range(7));
        r.tickets = TICKET_W'($urandom);
        if (kind < 30)
        begin
            r.func = FN_STATUS;
            case ($urandom_range(9))
                0, 1, 2, 3: r.status = ST_RUNNABLE;
                4, 5:       r.status = ST_SLEEPING;
                6:          r.status = ST_EMBRYO;
                default:    ;
            endcase
        end
        else if (kind < 50)
        begin
            r.func = FN_TICKETS;
            case ($urandom_range(9))
                0:       r.tickets = '0;
                1:       r.tickets = '1;
                2, 3, 4: r.tickets = TICKET_W'($urandom_range(255));
                default: ;
            endcase
        end
        else if (kind < 95)
            r.func = FN_ROUND;
        else
            r.func = FN_NONE;
        return r;
    endfunction

    initial
    begin
        logic [31:0] seeds [4];
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_STATUS;
        req_ch.slot_index = '0;
        req_ch.new_status = '0;
        req_ch.ticket_count = '0;
        fail_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        for (int s = 0; s < N_SLOTS; s++)
        begin
            shadow_status[s] = ST_UNUSED;
            shadow_tickets[s] = '0;
            shadow_boost[s] = 0;
        end
        shadow_gen = '0;

        // Directed table: empty rounds and non-round requests read all zero.
        add_row(FN_ROUND,   0,  ST_UNUSED,   0, 1'b1);
        add_row(FN_NONE,    63, 3'd7,        65535, 1'b1);
        add_row(FN_STATUS,  63, ST_RUNNABLE, 0, 1'b1);
        // Runnable slot with zero tickets: still an empty round.
        add_row(FN_ROUND,   0,  ST_UNUSED,   0, 1'b1);
        add_row(FN_TICKETS, 63, ST_UNUSED,   65535, 1'b1);
        add_row(FN_STATUS,  0,  ST_RUNNABLE, 0);
        add_row(FN_ROUND,   0,  ST_UNUSED,   0);
        // Sleeping slot gathers boost, then runs with doubled weight.
        add_row(FN_STATUS,  10, ST_SLEEPING, 0);
        add_row(FN_TICKETS, 10, ST_UNUSED,   40000);
        for (int k = 0; k < 3; k++)
            add_row(FN_ROUND, 0, ST_UNUSED, 0);
        add_row(FN_STATUS,  10, ST_RUNNABLE, 0);
        add_row(FN_STATUS,  63, ST_RUNNABLE, 0);
        add_row(FN_ROUND,   0,  ST_UNUSED,   0);
        // Embryo drops the boost.
        add_row(FN_STATUS,  10, ST_EMBRYO,   0);
        add_row(FN_STATUS,  10, ST_RUNNABLE, 0);
        add_row(FN_STATUS,  20, 3'd6,        0);
        add_row(FN_STATUS,  21, 3'd7,        0);
        add_row(FN_STATUS,  22, ST_ZOMBIE,   0);
        add_row(FN_TICKETS, 20, ST_UNUSED,   65535);
        add_row(FN_ROUND,   0,  ST_UNUSED,   0);
        add_row(FN_STATUS,  63, ST_RUNNING,  0);
        add_row(FN_ROUND,   0,  ST_UNUSED,   0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_seed(32'hffffffff);
        foreach (directed[k])
            send_request(directed[k].req, directed[k].typed, directed[k].want);
        drain();

        seeds[0] = 32'h0;
        seeds[1] = 32'h7fffffff;
        seeds[2] = $urandom;
        seeds[3] = 32'h80000000;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_seed(seeds[ph]);
            // One phase runs with no idling on either side.
            no_idle = (ph == 2);
            for (int k = 0; k < ITEMS_PHASE; k++)
            begin
                // Pause the sender once until everything is back.
                if (ph == 1 && k == ITEMS_PHASE / 2)
                    while (pending_rsp.size() != 0)
                        @(posedge clk);
                send_request(random_request(), 1'b0, '0);
            end
            no_idle = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lsb_pkg.sv
hw/rtl/lsb_req_if.sv
hw/rtl/lsb_rsp_if.sv
hw/rtl/lsb_mod.sv
hw/rtl/lottery_scheduler_with_boost_unit.sv
dv/tb_lottery_scheduler_with_boost_unit.sv
